@@ sv/gdk_pkg.sv @@
// Shared types, constants and kernel functions of the gray dual-kernel 3x3 filter.
package gdk_pkg;

  // Gray level of one pixel: floor(33 * sum / 100) as (sum * 33 * 5243) >> 19.
  localparam int unsigned GRAY_MULT  = 173019;
  localparam int          GRAY_SHIFT = 19;

  localparam logic [9:0] WIDTH_RESET  = 10'd512;
  localparam logic [9:0] HEIGHT_RESET = 10'd512;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } gdk_reg_t;

  // One window column: [0] top row, [1] middle row, [2] bottom row.
  typedef logic [2:0][7:0] gdk_col_t;

  // Position and flags of an item as it leaves the line store read stage.
  typedef struct packed {
    logic       top_ok;
    logic       mid_ok;
    logic       first_col;
    logic       emit;
    logic       two;
    logic       eof;
    logic [8:0] row;
    logic [8:0] col;
  } gdk_pos_t;

  // Both kernel responses for the regular centre (a) and the row-end centre (b).
  typedef struct packed {
    logic [7:0] grad_a;
    logic [7:0] emb_a;
    logic [7:0] grad_b;
    logic [7:0] emb_b;
  } gdk_kern_t;

  typedef struct packed {
    logic [7:0] gradient_out;
    logic [7:0] emboss_out;
    logic [8:0] out_row;
    logic [8:0] out_col;
    logic       last_of_run;
    logic       end_of_frame;
  } gdk_res_t;

  function automatic logic signed [11:0] ext(input logic [7:0] v);
    return signed'({4'b0000, v});
  endfunction

  function automatic logic [7:0] clamp_byte(input logic signed [11:0] v);
    logic [7:0] r;
    if (v < 0) r = 8'd0;
    else if (v > 12'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction

  function automatic logic [7:0] sobel_v(input gdk_col_t l, input gdk_col_t c,
                                         input gdk_col_t r);
    logic signed [11:0] s;
    s = ext(l[2]) + (ext(c[2]) <<< 1) + ext(r[2])
      - ext(l[0]) - (ext(c[0]) <<< 1) - ext(r[0]);
    return clamp_byte(s);
  endfunction

  function automatic logic [7:0] emboss(input gdk_col_t l, input gdk_col_t c,
                                        input gdk_col_t r);
    logic signed [11:0] s;
    s = ext(c[1]) + ext(r[1]) + ext(c[2]) + (ext(r[2]) <<< 1)
      - (ext(l[0]) <<< 1) - ext(c[0]) - ext(l[1]);
    return clamp_byte(s);
  endfunction

endpackage

@@ sv/gdk_channels.sv @@
// Handshake channel interfaces: pixel input, filter results and register writes.
interface gdk_pix_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, cmd, red, green, blue, input ready);
  modport sink (input valid, cmd, red, green, blue, output ready);
endinterface

interface gdk_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] gradient_out;
  logic [7:0] emboss_out;
  logic [8:0] out_row;
  logic [8:0] out_col;
  logic       last_of_run;
  logic       end_of_frame;
  modport source (output valid, gradient_out, emboss_out, out_row, out_col,
                  last_of_run, end_of_frame, input ready);
  modport sink (input valid, gradient_out, emboss_out, out_row, out_col,
                last_of_run, end_of_frame, output ready);
endinterface

interface gdk_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [9:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/gray_dual_kernel_conv3x3.sv @@
// Top level of the gray conversion and dual 3x3 kernel filter.
// Pixels arrive in raster order at one beat per clock while the result port is
// ready and are turned into gray levels; two line stores of MAX_WIDTH bytes each
// are read when a pixel is taken and written back as it leaves the read stage
// for the output buffer. Each pixel yields one result once the first row and
// column are past; the last pixel of a row yields two. The first pixel of the
// next row yields none, so the second result of a row end goes out in that slot
// and the input keeps one beat per clock while the result port is ready. The
// bottom row is finished by one row of padding beats after the frame. The line
// stores need no clearing after reset. Writing frame_width or frame_height
// restarts the frame; writes are meant for an idle block.
module gray_dual_kernel_conv3x3 #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic      clk,
  input  logic      rst,
  gdk_pix_if.sink   pix,
  gdk_cfg_if.sink   cfg,
  gdk_res_if.source res
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  logic [9:0]        frame_width;
  logic [9:0]        frame_height;
  logic [WW-1:0]     used_w;
  logic [RW-1:0]     used_h;
  logic [AW-1:0]     col_last;
  logic [AW-1:0]     col_cnt;
  logic [RW-1:0]     row_cnt;

  logic              accept;
  logic              at_last;
  logic              padding;
  logic [9:0]        rgb_sum;
  logic [27:0]       gray_prod;
  logic [7:0]        gray;
  gdk_pkg::gdk_pos_t pos;

  logic              s1_valid;
  logic [7:0]        s1_gray;
  logic [AW-1:0]     s1_addr;
  gdk_pkg::gdk_pos_t s1_pos;
  logic              s1_fire;
  logic [7:0]        upper_rd;
  logic [7:0]        lower_rd;
  gdk_pkg::gdk_col_t right;
  gdk_pkg::gdk_kern_t kern;
  logic              buf_room;

  // Register values outside the usable range are saturated.
  always_comb begin
    if (frame_width > MAX_WIDTH) used_w = WW'(MAX_WIDTH);
    else if (frame_width < 10'd2) used_w = WW'(2);
    else used_w = WW'(frame_width);
    if (frame_height > MAX_HEIGHT) used_h = RW'(MAX_HEIGHT);
    else if (frame_height == 10'd0) used_h = RW'(1);
    else used_h = RW'(frame_height);
    col_last = AW'(used_w - WW'(1));
  end

  assign cfg.ready = 1'b1;
  assign accept    = pix.valid & pix.ready;
  assign pix.ready = !s1_valid || s1_fire;

  always_comb begin
    at_last   = (col_cnt == col_last);
    padding   = pix.cmd || (row_cnt == used_h);
    rgb_sum   = 10'(pix.red) + 10'(pix.green) + 10'(pix.blue);
    gray_prod = 28'(rgb_sum) * 28'(gdk_pkg::GRAY_MULT);
    gray      = padding ? 8'd0 : gray_prod[gdk_pkg::GRAY_SHIFT +: 8];

    pos.top_ok    = (row_cnt > RW'(1));
    pos.mid_ok    = (row_cnt != '0);
    pos.first_col = (col_cnt == '0);
    pos.emit      = pos.mid_ok && !pos.first_col;
    pos.two       = at_last;
    pos.eof       = at_last && (row_cnt == used_h);
    pos.row       = 9'(row_cnt) - 9'd1;
    pos.col       = 9'(col_cnt) - 9'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= gdk_pkg::WIDTH_RESET;
      frame_height <= gdk_pkg::HEIGHT_RESET;
      col_cnt      <= '0;
      row_cnt      <= '0;
    end else if (cfg.valid) begin
      case (gdk_pkg::gdk_reg_t'(cfg.index))
        gdk_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg.data;
        gdk_pkg::REG_FRAME_HEIGHT: frame_height <= cfg.data;
        default: ;
      endcase
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (at_last) begin
        col_cnt <= '0;
        row_cnt <= (row_cnt == used_h) ? '0 : row_cnt + RW'(1);
      end else begin
        col_cnt <= col_cnt + AW'(1);
      end
    end
  end

  // Read stage: the line store data for this beat arrives with it in stage one.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_gray <= gray;
      s1_addr <= col_cnt;
      s1_pos  <= pos;
    end
  end

  assign s1_fire = s1_valid && (!s1_pos.emit || buf_room);

  // Rows not yet stored in this frame read as zero.
  always_comb begin
    right[0] = s1_pos.top_ok ? upper_rd : 8'd0;
    right[1] = s1_pos.mid_ok ? lower_rd : 8'd0;
    right[2] = s1_gray;
  end

  // Consecutive beats use different columns, so a write never meets a read of
  // the same entry.
  gdk_line_mem #(.DEPTH(MAX_WIDTH), .AW(AW)) u_upper (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cnt),
    .rd_data (upper_rd),
    .wr_en   (s1_fire),
    .wr_addr (s1_addr),
    .wr_data (right[1])
  );

  gdk_line_mem #(.DEPTH(MAX_WIDTH), .AW(AW)) u_lower (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cnt),
    .rd_data (lower_rd),
    .wr_en   (s1_fire),
    .wr_addr (s1_addr),
    .wr_data (s1_gray)
  );

  gdk_window u_window (
    .clk       (clk),
    .rst       (rst),
    .fire      (s1_fire),
    .first_col (s1_pos.first_col),
    .right     (right),
    .kern      (kern)
  );

  gdk_out_buf u_out_buf (
    .clk  (clk),
    .rst  (rst),
    .load (s1_fire && s1_pos.emit),
    .kern (kern),
    .pos  (s1_pos),
    .room (buf_room),
    .res  (res)
  );

endmodule

@@ sv/gdk_line_mem.sv @@
// One gray line store: synchronous memory with a registered read port.
module gdk_line_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/gdk_window.sv @@
// Two-column window register and the Sobel and emboss kernels over it.
module gdk_window (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic              first_col,
  input  gdk_pkg::gdk_col_t right,
  output gdk_pkg::gdk_kern_t kern
);

  gdk_pkg::gdk_col_t left_col;
  gdk_pkg::gdk_col_t centre_col;
  gdk_pkg::gdk_col_t left_eff;
  gdk_pkg::gdk_col_t centre_eff;

  // At the start of a row the window holds nothing from the row before.
  always_comb begin
    left_eff    = first_col ? '0 : left_col;
    centre_eff  = first_col ? '0 : centre_col;
    kern.grad_a = gdk_pkg::sobel_v(left_eff, centre_eff, right);
    kern.emb_a  = gdk_pkg::emboss(left_eff, centre_eff, right);
    kern.grad_b = gdk_pkg::sobel_v(centre_eff, right, '0);
    kern.emb_b  = gdk_pkg::emboss(centre_eff, right, '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_col   <= '0;
      centre_col <= '0;
    end else if (fire) begin
      left_col   <= centre_eff;
      centre_col <= right;
    end
  end

endmodule

@@ sv/gdk_out_buf.sv @@
// Two-entry result buffer that splits a row-end item into its two result beats.
module gdk_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  gdk_pkg::gdk_kern_t kern,
  input  gdk_pkg::gdk_pos_t  pos,
  output logic               room,
  gdk_res_if.source          res
);

  gdk_pkg::gdk_res_t slot [2];
  gdk_pkg::gdk_res_t res_a;
  gdk_pkg::gdk_res_t res_b;
  logic [1:0]        count;
  logic              take;

  always_comb begin
    res_a = '{gradient_out: kern.grad_a, emboss_out: kern.emb_a, out_row: pos.row,
              out_col: pos.col, last_of_run: !pos.two, end_of_frame: 1'b0};
    res_b = '{gradient_out: kern.grad_b, emboss_out: kern.emb_b, out_row: pos.row,
              out_col: pos.col + 9'd1, last_of_run: 1'b1, end_of_frame: pos.eof};
  end

  assign take = res.valid & res.ready;
  assign room = (count == 2'd0) || ((count == 2'd1) && take);

  assign res.valid        = (count != 2'd0);
  assign res.gradient_out = slot[0].gradient_out;
  assign res.emboss_out   = slot[0].emboss_out;
  assign res.out_row      = slot[0].out_row;
  assign res.out_col      = slot[0].out_col;
  assign res.last_of_run  = slot[0].last_of_run;
  assign res.end_of_frame = slot[0].end_of_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= pos.two ? 2'd2 : 2'd1;
    end else if (take) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot[0] <= res_a;
      slot[1] <= res_b;
    end else if (take) begin
      slot[0] <= slot[1];
    end
  end

endmodule

@@ sv/gdk_checker.sv @@
// Port-level checks of the filter's result stream, bound to the top level.
module gdk_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_gradient,
  input logic       res_last,
  input logic       res_eof
);

  // A result beat that is not taken stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_gradient))
    else $error("result payload changed while stalled");

  // The first of a pair is buffered together with the second.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res_last |=> res_valid && res_last)
    else $error("second result of a row end did not follow");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_eof |-> res_last)
    else $error("end of frame on a result that does not close its run");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result offered right after reset");

endmodule

bind gray_dual_kernel_conv3x3 gdk_checker u_gdk_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_gradient (res.gradient_out),
  .res_last     (res.last_of_run),
  .res_eof      (res.end_of_frame)
);
